[design/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and a helper of the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] FLAG_BYTE       = 8'h7E;
  localparam logic [7:0] ESC_BYTE        = 8'h7D;
  localparam logic [7:0] STUFF_XOR       = 8'h20;
  localparam logic [7:0] ADDR_RESET      = 8'h03;
  localparam int         SFR_QUEUE_DEPTH = 4;

  localparam logic [7:0] CTRL_SET  = 8'h03;
  localparam logic [7:0] CTRL_UA   = 8'h07;
  localparam logic [7:0] CTRL_DISC = 8'h0B;
  localparam logic [7:0] CTRL_RR0  = 8'hAA;
  localparam logic [7:0] CTRL_RR1  = 8'hAB;
  localparam logic [7:0] CTRL_REJ0 = 8'h54;
  localparam logic [7:0] CTRL_REJ1 = 8'h55;
  localparam logic [7:0] CTRL_I0   = 8'h00;
  localparam logic [7:0] CTRL_I1   = 8'h80;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PUSH  = 2'd1,
    OP_END   = 2'd2,
    OP_ABORT = 2'd3
  } op_code_t;

  typedef struct packed {
    op_code_t   code;
    logic [7:0] value;
  } op_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_GOOD        = 2'd0,
    STATUS_CHECK_ERR   = 2'd1,
    STATUS_ABORT       = 2'd2,
    STATUS_SUPERVISORY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REPLY_NONE = 3'd0,
    REPLY_RR0  = 3'd1,
    REPLY_RR1  = 3'd2,
    REPLY_REJ0 = 3'd3,
    REPLY_REJ1 = 3'd4
  } reply_t;

  function automatic logic ctrl_accepted(input logic [7:0] b);
    return (b == CTRL_SET)  || (b == CTRL_UA)   || (b == CTRL_DISC) ||
           (b == CTRL_RR0)  || (b == CTRL_RR1)  || (b == CTRL_REJ0) ||
           (b == CTRL_REJ1) || (b == CTRL_I0)   || (b == CTRL_I1);
  endfunction

endpackage

[design/sfr_if.sv]
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels of the stuffed frame receiver.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic [7:0]  control_code;
  logic [2:0]  reply;
  logic [15:0] payload_length;

  modport source (output valid, output kind, output data_byte, output status,
                  output control_code, output reply, output payload_length,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input control_code, input reply, input payload_length,
                  output ready);
endinterface

[design/stuffed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// stuffed_frame_receiver
// Byte-stuffed link frame receiver: header check, unstuffing, frame reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw line byte per item; out_ch carries one result item,
//   either an unstuffed payload byte (kind 0) or a frame-end report (kind 1).
//   cfg_we/cfg_wdata write the expected address byte (reset value 3); write
//   it only while the block is idle.
// Path: the result of an accepted item passes through the operation queue
//   and then the output register. Payload bytes trail the line by one item,
//   so the check byte in front of the closing flag is never delivered.
// Throughput: one item per cycle while out_ch is not held off. The front end
//   parses and unstuffs at line rate; the back end retires one queued
//   operation per cycle into the output register.
// Reset: the parser hunts for an opening flag, the sequence bit is 0 and no
//   result is pending.
// Stall: when out_ch is held off, the back end stops; the front end keeps
//   taking items until the operation queue (QUEUE_DEPTH entries) is full,
//   then drops in_ch.ready.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver #(
  parameter int QUEUE_DEPTH = sfr_pkg::SFR_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  sfr_in_if.sink     in_ch,
  sfr_out_if.source  out_ch
);
  import sfr_pkg::*;

  logic q_full, q_not_empty, q_pop, op_push;
  op_t  front_op, back_op;
  logic in_ready;

  assign in_ch.ready = in_ready;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.rx_byte),
    .q_full    (q_full),
    .in_ready  (in_ready),
    .op_push   (op_push),
    .op        (front_op)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .wr_op     (front_op),
    .pop       (q_pop),
    .rd_op     (back_op),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  sfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (q_not_empty),
    .op       (back_op),
    .op_pop   (q_pop),
    .out_ch   (out_ch)
  );

endmodule

[design/sfr_front.sv]
// ----------------------------------------------------------------------------
// sfr_front
// Header parse and unstuffing; turns line bytes into back-end operations.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,
  input  logic         in_valid,
  input  logic [7:0]   in_byte,
  input  logic         q_full,
  output logic         in_ready,
  output logic         op_push,
  output sfr_pkg::op_t op
);
  import sfr_pkg::*;

  typedef enum logic [5:0] {
    S_HUNT = 6'b000001,
    S_FLAG = 6'b000010,
    S_ADDR = 6'b000100,
    S_CTRL = 6'b001000,
    S_DATA = 6'b010000,
    S_ESC  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] addr_cfg_r;
  logic [7:0] hdr_addr_r, hdr_addr_nxt;
  logic [7:0] hdr_ctrl_r, hdr_ctrl_nxt;
  logic       take;

  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    state_nxt    = state_r;
    hdr_addr_nxt = hdr_addr_r;
    hdr_ctrl_nxt = hdr_ctrl_r;
    op_push      = 1'b0;
    op.code      = OP_PUSH;
    op.value     = in_byte;
    if (take) begin
      case (state_r)
        S_HUNT: begin
          if (in_byte == FLAG_BYTE) state_nxt = S_FLAG;
        end
        S_FLAG: begin
          if (in_byte == addr_cfg_r) begin
            hdr_addr_nxt = in_byte;
            state_nxt    = S_ADDR;
          end
        end
        S_ADDR: begin
          if (ctrl_accepted(in_byte)) begin
            hdr_ctrl_nxt = in_byte;
            state_nxt    = S_CTRL;
          end else if (in_byte == FLAG_BYTE) begin
            state_nxt = S_FLAG;
          end
        end
        S_CTRL: begin
          if (in_byte == (hdr_addr_r ^ hdr_ctrl_r)) begin
            op_push   = 1'b1;
            op.code   = OP_START;
            state_nxt = S_DATA;
          end else if (in_byte == FLAG_BYTE) begin
            state_nxt = S_FLAG;
          end
        end
        S_DATA: begin
          if (in_byte == FLAG_BYTE) begin
            op_push   = 1'b1;
            op.code   = OP_END;
            op.value  = hdr_ctrl_r;
            state_nxt = S_HUNT;
          end else if (in_byte == ESC_BYTE) begin
            state_nxt = S_ESC;
          end else begin
            op_push = 1'b1;
          end
        end
        S_ESC: begin
          op_push = 1'b1;
          if (in_byte == (FLAG_BYTE ^ STUFF_XOR)) begin
            op.value  = FLAG_BYTE;
            state_nxt = S_DATA;
          end else if (in_byte == (ESC_BYTE ^ STUFF_XOR)) begin
            op.value  = ESC_BYTE;
            state_nxt = S_DATA;
          end else begin
            op.code   = OP_ABORT;
            op.value  = hdr_ctrl_r;
            state_nxt = S_HUNT;
          end
        end
        default: begin
          state_nxt = S_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_HUNT;
      addr_cfg_r <= ADDR_RESET;
      hdr_addr_r <= '0;
      hdr_ctrl_r <= '0;
    end else begin
      state_r    <= state_nxt;
      hdr_addr_r <= hdr_addr_nxt;
      hdr_ctrl_r <= hdr_ctrl_nxt;
      if (cfg_we) addr_cfg_r <= cfg_wdata;
    end
  end

endmodule

[design/sfr_queue.sv]
// ----------------------------------------------------------------------------
// sfr_queue
// Short operation queue between the front and back ends.
// ----------------------------------------------------------------------------
module sfr_queue #(
  parameter int DEPTH = sfr_pkg::SFR_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  sfr_pkg::op_t wr_op,
  input  logic         pop,
  output sfr_pkg::op_t rd_op,
  output logic         not_empty,
  output logic         full
);
  import sfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  op_t              mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_op     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[design/sfr_back.sv]
// ----------------------------------------------------------------------------
// sfr_back
// Payload hold, check accumulation and frame-end reporting.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         op_valid,
  input  sfr_pkg::op_t op,
  output logic         op_pop,
  sfr_out_if.source    out_ch
);
  import sfr_pkg::*;

  logic [7:0]  held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        seq_r, seq_nxt;

  logic        out_valid_r;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  status_t     status_r, status_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  reply_t      reply_r, reply_nxt;
  logic [15:0] len_r, len_nxt;
  logic        emit;

  assign op_pop = op_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    xor_nxt    = xor_r;
    cnt_nxt    = cnt_r;
    seq_nxt    = seq_r;
    emit       = 1'b0;
    kind_nxt   = KIND_DATA;
    data_nxt   = held_r;
    status_nxt = STATUS_GOOD;
    ctrl_nxt   = '0;
    reply_nxt  = REPLY_NONE;
    len_nxt    = '0;
    if (op_pop) begin
      case (op.code)
        OP_START: begin
          held_nxt   = '0;
          held_v_nxt = 1'b0;
          xor_nxt    = '0;
          cnt_nxt    = '0;
        end
        OP_PUSH: begin
          if (held_v_r) begin
            emit    = 1'b1;
            xor_nxt = xor_r ^ held_r;
            if (cnt_r != 16'hFFFF) cnt_nxt = cnt_r + 16'd1;
          end
          held_nxt   = op.value;
          held_v_nxt = 1'b1;
        end
        OP_END: begin
          emit     = 1'b1;
          kind_nxt = KIND_END;
          data_nxt = '0;
          ctrl_nxt = op.value;
          len_nxt  = cnt_r;
          if (!held_v_r) begin
            status_nxt = STATUS_SUPERVISORY;
          end else if (xor_r == held_r) begin
            status_nxt = STATUS_GOOD;
            reply_nxt  = seq_r ? REPLY_RR0 : REPLY_RR1;
            seq_nxt    = !seq_r;
          end else begin
            status_nxt = STATUS_CHECK_ERR;
            reply_nxt  = seq_r ? REPLY_REJ0 : REPLY_REJ1;
          end
        end
        OP_ABORT: begin
          emit       = 1'b1;
          kind_nxt   = KIND_END;
          data_nxt   = '0;
          status_nxt = STATUS_ABORT;
          ctrl_nxt   = op.value;
          len_nxt    = cnt_r;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      held_v_r    <= 1'b0;
      xor_r       <= '0;
      cnt_r       <= '0;
      seq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      xor_r    <= xor_nxt;
      cnt_r    <= cnt_nxt;
      seq_r    <= seq_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r   <= kind_nxt;
      data_r   <= data_nxt;
      status_r <= status_nxt;
      ctrl_r   <= ctrl_nxt;
      reply_r  <= reply_nxt;
      len_r    <= len_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.data_byte      = data_r;
  assign out_ch.status         = status_r;
  assign out_ch.control_code   = ctrl_r;
  assign out_ch.reply          = reply_r;
  assign out_ch.payload_length = len_r;

endmodule

[design/sfr_checker.sv]
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the stuffed frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [1:0]  out_status,
  input logic [7:0]  out_control_code,
  input logic [2:0]  out_reply,
  input logic [15:0] out_payload_length
);
  import sfr_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result pending right after reset");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DATA) |->
      (out_status == STATUS_GOOD) && (out_reply == REPLY_NONE) &&
      (out_control_code == 8'h00) && (out_payload_length == 16'h0000))
    else $error("payload item carries frame-end fields");

  a_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_END) &&
    ((out_status == STATUS_ABORT) || (out_status == STATUS_SUPERVISORY)) |->
      (out_reply == REPLY_NONE))
    else $error("reply on abort or supervisory frame");

  a_good_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_END) && (out_status == STATUS_GOOD) |->
      (out_reply == REPLY_RR0) || (out_reply == REPLY_RR1))
    else $error("good frame without receive-ready reply");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_status         (out_ch.status),
  .out_control_code   (out_ch.control_code),
  .out_reply          (out_ch.reply),
  .out_payload_length (out_ch.payload_length)
);

[bench/tb_stuffed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// tb_stuffed_frame_receiver
// Drives line bytes into the stuffed frame receiver: a few hand-built frames
// covering header restarts, stuffing, supervisory, check error and escape
// abort, then random frames under five address settings. A scoreboard
// predicts every payload byte and frame report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import sfr_pkg::*;

typedef enum logic [2:0] {
  PH_HUNT,
  PH_FLAG,
  PH_ADDR,
  PH_CTRL,
  PH_PAYLOAD,
  PH_ESC
} line_phase_t;

typedef enum int {
  FRAME_GOOD,
  FRAME_BAD_CHECK,
  FRAME_SUPERVISORY,
  FRAME_BAD_ESCAPE
} frame_flavor_t;

typedef struct packed {
  kind_t       kind;
  logic [7:0]  data_byte;
  status_t     status;
  logic [7:0]  control_code;
  reply_t      reply;
  logic [15:0] payload_length;
} frame_result_t;

class deframe_scoreboard;
  logic [7:0]    station_address;
  line_phase_t   phase;
  logic [7:0]    hdr_addr;
  logic [7:0]    hdr_ctrl;
  logic [7:0]    payload_xor;
  logic [7:0]    held_byte;
  bit            held_valid;
  logic [15:0]   emitted_count;
  bit            seq_bit;
  frame_result_t pending_results[$];
  int unsigned   mismatch_count;

  function new();
    station_address = ADDR_RESET;
    phase           = PH_HUNT;
    hdr_addr        = '0;
    hdr_ctrl        = '0;
    payload_xor     = '0;
    held_byte       = '0;
    held_valid      = 1'b0;
    emitted_count   = '0;
    seq_bit         = 1'b0;
    mismatch_count  = 0;
  endfunction

  function void set_address(logic [7:0] value);
    station_address = value;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void expect_item(kind_t k, logic [7:0] d, status_t s, logic [7:0] c,
                            reply_t r, logic [15:0] n);
    frame_result_t e;
    e.kind           = k;
    e.data_byte      = d;
    e.status         = s;
    e.control_code   = c;
    e.reply          = r;
    e.payload_length = n;
    pending_results.push_back(e);
  endfunction

  // Release the held byte and hold the new one.
  function void take_payload(logic [7:0] b);
    if (held_valid) begin
      expect_item(KIND_DATA, held_byte, STATUS_GOOD, 8'h00, REPLY_NONE, 16'h0000);
      payload_xor ^= held_byte;
      if (emitted_count != 16'hFFFF) emitted_count++;
    end
    held_byte  = b;
    held_valid = 1'b1;
  endfunction

  function void note_line_byte(logic [7:0] b);
    status_t s;
    reply_t  r;
    case (phase)
      PH_HUNT: begin
        if (b == FLAG_BYTE) phase = PH_FLAG;
      end
      PH_FLAG: begin
        if (b == station_address) begin
          hdr_addr = b;
          phase    = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (b inside {CTRL_SET, CTRL_UA, CTRL_DISC, CTRL_RR0, CTRL_RR1,
                      CTRL_REJ0, CTRL_REJ1, CTRL_I0, CTRL_I1}) begin
          hdr_ctrl = b;
          phase    = PH_CTRL;
        end else if (b == FLAG_BYTE) begin
          phase = PH_FLAG;
        end
      end
      PH_CTRL: begin
        if (b == (hdr_addr ^ hdr_ctrl)) begin
          payload_xor   = '0;
          held_byte     = '0;
          held_valid    = 1'b0;
          emitted_count = '0;
          phase         = PH_PAYLOAD;
        end else if (b == FLAG_BYTE) begin
          phase = PH_FLAG;
        end
      end
      PH_PAYLOAD: begin
        if (b == FLAG_BYTE) begin
          r = REPLY_NONE;
          if (!held_valid) begin
            s = STATUS_SUPERVISORY;
          end else if (payload_xor == held_byte) begin
            s       = STATUS_GOOD;
            r       = seq_bit ? REPLY_RR0 : REPLY_RR1;
            seq_bit = !seq_bit;
          end else begin
            s = STATUS_CHECK_ERR;
            r = seq_bit ? REPLY_REJ0 : REPLY_REJ1;
          end
          expect_item(KIND_END, 8'h00, s, hdr_ctrl, r, emitted_count);
          phase = PH_HUNT;
        end else if (b == ESC_BYTE) begin
          phase = PH_ESC;
        end else begin
          take_payload(b);
        end
      end
      PH_ESC: begin
        if (b == (FLAG_BYTE ^ STUFF_XOR)) begin
          phase = PH_PAYLOAD;
          take_payload(FLAG_BYTE);
        end else if (b == (ESC_BYTE ^ STUFF_XOR)) begin
          phase = PH_PAYLOAD;
          take_payload(ESC_BYTE);
        end else begin
          expect_item(KIND_END, 8'h00, STATUS_ABORT, hdr_ctrl, REPLY_NONE,
                      emitted_count);
          phase = PH_HUNT;
        end
      end
      default: begin
        phase = PH_HUNT;
      end
    endcase
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: kind %0d data 0x%0h status %0d",
             got.kind, got.data_byte, got.status);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("kind", 16'(want.kind), 16'(got.kind));
    compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
    compare_field("status", 16'(want.status), 16'(got.status));
    compare_field("control_code", 16'(want.control_code), 16'(got.control_code));
    compare_field("reply", 16'(want.reply), 16'(got.reply));
    compare_field("payload_length", want.payload_length, got.payload_length);
  endfunction
endclass

module tb_stuffed_frame_receiver;

  localparam int STALL_LIMIT = 2000;
  localparam int CHUNK_ITEMS = 60;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  bit         steady;
  int         line_items;
  int         stall_cycles;
  logic [7:0] current_address;

  deframe_scoreboard board;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  stuffed_frame_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin : monitor
    frame_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_line_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.kind           = kind_t'(out_ch.kind);
        got.data_byte      = out_ch.data_byte;
        got.status         = status_t'(out_ch.status);
        got.control_code   = out_ch.control_code;
        got.reply          = reply_t'(out_ch.reply);
        got.payload_length = out_ch.payload_length;
        board.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_stuffed_frame_receiver: errors");
      $finish;
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_line_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] burst[$]);
    foreach (burst[i]) send_line_byte(burst[i]);
    line_items += burst.size();
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_address(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_address(value);
    current_address = value;
  endtask

  function automatic void stuff_byte(ref logic [7:0] burst[$], input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      burst.push_back(ESC_BYTE);
      burst.push_back(b ^ STUFF_XOR);
    end else begin
      burst.push_back(b);
    end
  endfunction

  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 3))
        0:       return FLAG_BYTE;
        1:       return ESC_BYTE;
        2:       return FLAG_BYTE ^ STUFF_XOR;
        default: return ESC_BYTE ^ STUFF_XOR;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] ctrl,
                            input logic [7:0] body[$], input frame_flavor_t flavor,
                            input bit header_noise);
    logic [7:0] burst[$];
    logic [7:0] check;
    logic [7:0] bad;
    burst.push_back(FLAG_BYTE);
    burst.push_back(addr);
    if (header_noise) burst.push_back(8'($urandom_range(0, 255)));
    burst.push_back(ctrl);
    burst.push_back(addr ^ ctrl);
    if (flavor == FRAME_SUPERVISORY) begin
      burst.push_back(FLAG_BYTE);
    end else begin
      check = '0;
      foreach (body[i]) begin
        check ^= body[i];
        stuff_byte(burst, body[i]);
      end
      if (flavor == FRAME_BAD_ESCAPE) begin
        do begin
          bad = 8'($urandom_range(0, 255));
        end while (bad == (FLAG_BYTE ^ STUFF_XOR) || bad == (ESC_BYTE ^ STUFF_XOR));
        burst.push_back(ESC_BYTE);
        burst.push_back(bad);
      end else begin
        if (flavor == FRAME_BAD_CHECK) check ^= 8'($urandom_range(1, 255));
        stuff_byte(burst, check);
        burst.push_back(FLAG_BYTE);
      end
    end
    send_bytes(burst);
  endtask

  task automatic send_random_frame();
    logic [7:0]    ctrl_codes[9];
    logic [7:0]    noise[$];
    logic [7:0]    body[$];
    logic [7:0]    addr;
    logic [7:0]    ctrl;
    frame_flavor_t flavor;
    int            pick;
    int            len;
    ctrl_codes = '{CTRL_SET, CTRL_UA, CTRL_DISC, CTRL_RR0, CTRL_RR1,
                   CTRL_REJ0, CTRL_REJ1, CTRL_I0, CTRL_I1};
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 3)) noise.push_back(8'($urandom_range(0, 255)));
      send_bytes(noise);
    end
    addr = ($urandom_range(0, 99) < 90) ? current_address : 8'($urandom_range(0, 255));
    ctrl = ($urandom_range(0, 99) < 85) ? ctrl_codes[$urandom_range(0, 8)]
                                        : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 60)      flavor = FRAME_GOOD;
    else if (pick < 75) flavor = FRAME_BAD_CHECK;
    else if (pick < 85) flavor = FRAME_SUPERVISORY;
    else                flavor = FRAME_BAD_ESCAPE;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
    repeat (len) body.push_back(payload_byte());
    send_frame(addr, ctrl, body, flavor, $urandom_range(0, 99) < 10);
  endtask

  initial begin
    logic [7:0] burst[$];
    logic [7:0] body[$];
    int         target;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = 8'h00;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 8'h00;
    rst_n           = 1'b0;
    steady          = 1'b0;
    line_items      = 0;
    stall_cycles    = 0;
    current_address = ADDR_RESET;
    board           = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // wrong address skipped, flag restarts header, stuffed flag/escape, 0xFF
    burst = {FLAG_BYTE, 8'h12, ADDR_RESET, FLAG_BYTE, ADDR_RESET, CTRL_SET,
             ADDR_RESET ^ CTRL_SET, ESC_BYTE, FLAG_BYTE ^ STUFF_XOR, ESC_BYTE,
             ESC_BYTE ^ STUFF_XOR, 8'hFF, FLAG_BYTE ^ ESC_BYTE ^ 8'hFF, FLAG_BYTE};
    send_bytes(burst);
    send_frame(ADDR_RESET, CTRL_RR0, body, FRAME_SUPERVISORY, 1'b0);
    send_frame(ADDR_RESET, CTRL_I0, body, FRAME_BAD_CHECK, 1'b0);
    send_frame(ADDR_RESET, CTRL_I1, body, FRAME_BAD_ESCAPE, 1'b0);

    for (int chunk = 0; chunk < 10; chunk++) begin
      if (chunk > 0) drain_results();
      case (chunk)
        2: write_address(8'h00);
        4: write_address(8'hFF);
        6: write_address(FLAG_BYTE);
        8: write_address(8'($urandom_range(0, 255)));
        default: ;
      endcase
      steady = (chunk == 4 || chunk == 5);
      target = line_items + CHUNK_ITEMS;
      while (line_items < target) send_random_frame();
    end

    drain_results();
    if (board.mismatch_count == 0) begin
      $display("tb_stuffed_frame_receiver: clean");
    end else begin
      $display("tb_stuffed_frame_receiver: errors");
    end
    $finish;
  end

endmodule
